// ----- hw/rtl/rch_pkg.sv -----
package rch_pkg;

    // Register indexes on the configuration port
    localparam int unsigned REG_REBIN_FACTOR = 0;

    localparam logic [10:0] REBIN_MAX = 11'd1024;

    typedef struct packed {
        logic        kind;
        logic [15:0] photon_count;
        logic [9:0]  read_index;
    } in_word_t;

    typedef struct packed {
        logic        aggregate_done;
        logic [31:0] aggregate_value;
        logic [31:0] bin_value;
        logic [31:0] overflow_total;
    } out_word_t;

    // Word kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    // Clamp the programmed factor into 1..1024
    function automatic logic [10:0] effective_factor(input logic [10:0] f);
        logic [10:0] r;
        if (f == 11'd0) begin
            r = 11'd1;
        end else if (f > REBIN_MAX) begin
            r = REBIN_MAX;
        end else begin
            r = f;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/rebinned_count_histogram.sv -----
// Rebinned photon counting histogram.
// Input channel s_*: one word per cycle, either a photon count sample
// (kind 0) or a read request for one histogram bin (kind 1). Every input
// word yields exactly one result word on m_* with the aggregate status, the
// requested bin and the overflow total after that word.
// rebin_factor (APB offset 0) sets how many samples form one aggregate;
// a write restarts the aggregate in progress. Write only while idle.
// Pipeline: stage 0 updates the running sum and issues the bin read, stage 1
// increments and writes back, and the output register then drives m_valid.
// Throughput: one word per cycle. The histogram RAM is read and written once
// per cycle; a read that hits the entry written in the previous cycle takes
// the forwarded value, so repeated hits on one bin do not stall.
// Reset: control state clears at once, then a clearing pass zeroes all
// HIST_BINS histogram RAM entries, one entry per cycle, with s_ready low.
// Stall: when m_ready is low with a result waiting, the whole pipeline
// holds and s_ready drops; nothing is dropped or repeated.
module rebinned_count_histogram #(
    parameter int unsigned HIST_BINS   = 1024,
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  rch_pkg::in_word_t  s_data,

    output logic               m_valid,
    input  logic               m_ready,
    output rch_pkg::out_word_t m_data,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int unsigned AW = $clog2(HIST_BINS);
    localparam int unsigned WW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
    localparam logic [31:0] BINS32 = 32'(HIST_BINS);

    // Configuration and stage 0 state
    logic [10:0] rebin_factor_reg;
    logic [31:0] running_sum_reg, running_sum_next;
    logic [10:0] bins_left_reg, bins_left_next;
    logic [31:0] overflow_reg, overflow_next;

    // Clearing pass
    logic          clr_active_reg;
    logic [AW-1:0] clr_addr_reg;

    // Stage 1
    logic          s1_valid_reg;
    logic          s1_kind_reg;
    logic          s1_done_reg;
    logic          s1_hit_reg;
    logic [31:0]   s1_agg_reg;
    logic [31:0]   s1_ovf_reg;
    logic [AW-1:0] s1_addr_reg;

    // Histogram RAM, registered read, and last write for forwarding
    logic [COUNT_WIDTH-1:0] hist_mem [HIST_BINS];
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   wb_valid_reg;
    logic [AW-1:0]          wb_addr_reg;
    logic [COUNT_WIDTH-1:0] wb_data_reg;

    // Output register
    logic                m_valid_reg;
    rch_pkg::out_word_t  m_data_reg;

    logic                   advance;
    logic                   accept;
    logic                   cfg_write;
    logic [32:0]            sum_wide;
    logic [31:0]            sum_sat;
    logic                   s0_done;
    logic                   s0_hit;
    logic [31:0]            s0_sel;
    logic [AW-1:0]          s0_addr;
    logic [COUNT_WIDTH-1:0] cur_count;
    logic [COUNT_WIDTH-1:0] new_count;
    logic [WW-1:0]          cur_wide;
    logic [31:0]            bin_out;
    logic                   s1_write;
    rch_pkg::out_word_t     out_next;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && paddr[2] == 1'b0;
    assign prdata    = (paddr[2] == 1'b0) ? {21'd0, rebin_factor_reg} : 32'd0;

    // Hold everything while a result waits on a stalled receiver
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance && !clr_active_reg;
    assign accept  = s_valid && s_ready;

    // Stage 0: saturating sum, aggregate completion, overflow count
    assign sum_wide = {1'b0, running_sum_reg} + 33'(s_data.photon_count);
    assign sum_sat  = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
    assign s0_done  = (s_data.kind == rch_pkg::KIND_SAMPLE) && (bins_left_reg <= 11'd1);
    assign s0_sel   = (s_data.kind == rch_pkg::KIND_SAMPLE) ? sum_sat
                                                            : {22'd0, s_data.read_index};
    assign s0_addr  = s0_sel[AW-1:0];
    assign s0_hit   = (s0_sel < BINS32) &&
                      (s0_done || s_data.kind == rch_pkg::KIND_READ);

    always_comb begin
        running_sum_next = running_sum_reg;
        bins_left_next   = bins_left_reg;
        overflow_next    = overflow_reg;
        if (s_data.kind == rch_pkg::KIND_SAMPLE) begin
            if (s0_done) begin
                running_sum_next = 32'd0;
                bins_left_next   = rch_pkg::effective_factor(rebin_factor_reg);
                if (!(sum_sat < BINS32) && overflow_reg != 32'hFFFF_FFFF) begin
                    overflow_next = overflow_reg + 32'd1;
                end
            end else begin
                running_sum_next = sum_sat;
                bins_left_next   = bins_left_reg - 11'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rebin_factor_reg <= 11'd1;
            running_sum_reg  <= 32'd0;
            bins_left_reg    <= rch_pkg::effective_factor(11'd1);
            overflow_reg     <= 32'd0;
        end else if (cfg_write) begin
            // Restart the aggregate in progress with the new factor
            rebin_factor_reg <= pwdata[10:0];
            running_sum_reg  <= 32'd0;
            bins_left_reg    <= rch_pkg::effective_factor(pwdata[10:0]);
        end else if (accept) begin
            running_sum_reg <= running_sum_next;
            bins_left_reg   <= bins_left_next;
            overflow_reg    <= overflow_next;
        end
    end

    // Stage 1 registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_kind_reg <= s_data.kind;
            s1_done_reg <= s0_done;
            s1_hit_reg  <= s0_hit;
            s1_agg_reg  <= s0_done ? sum_sat : 32'd0;
            s1_ovf_reg  <= overflow_next;
            s1_addr_reg <= s0_addr;
        end
    end

    // Stage 1: forward the last write when it hit the same entry
    assign cur_count = (wb_valid_reg && wb_addr_reg == s1_addr_reg) ? wb_data_reg
                                                                    : rd_data_reg;
    assign new_count = (cur_count == {COUNT_WIDTH{1'b1}}) ? cur_count
                                                         : cur_count + COUNT_WIDTH'(1);
    assign cur_wide  = WW'(cur_count);
    assign bin_out   = (cur_wide > WW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : cur_wide[31:0];
    assign s1_write  = advance && s1_valid_reg && s1_hit_reg &&
                       s1_kind_reg == rch_pkg::KIND_SAMPLE;

    always_comb begin
        out_next.aggregate_done  = s1_done_reg;
        out_next.aggregate_value = s1_agg_reg;
        out_next.bin_value       = (s1_kind_reg == rch_pkg::KIND_READ && s1_hit_reg)
                                   ? bin_out : 32'd0;
        out_next.overflow_total  = s1_ovf_reg;
    end

    // Histogram RAM: one write port (clear or update), one registered read
    always_ff @(posedge aclk) begin
        if (clr_active_reg) begin
            hist_mem[clr_addr_reg] <= '0;
        end else if (s1_write) begin
            hist_mem[s1_addr_reg] <= new_count;
        end
        if (advance) begin
            rd_data_reg <= hist_mem[s0_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            wb_valid_reg   <= 1'b0;
        end else begin
            if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(HIST_BINS - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (s1_write) begin
                wb_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_write) begin
            wb_addr_reg <= s1_addr_reg;
            wb_data_reg <= new_count;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- hw/rtl/rch_checker.sv -----
module rch_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input rch_pkg::out_word_t m_data
);

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word withdrawn while stalled");

    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result word changed while stalled");

    a_agg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.aggregate_done |-> m_data.aggregate_value == 32'd0)
        else $error("aggregate value without completed aggregate");

    a_bin_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.aggregate_done |-> m_data.bin_value == 32'd0)
        else $error("bin value on a sample word");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word right after reset");

endmodule

bind rebinned_count_histogram rch_checker u_rch_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
